@@ hdl/kbt_pkg.sv @@
package kbt_pkg;

    // table geometry
    localparam int TABLE_ENTRIES  = 256;
    localparam int KEY_BITS       = 16;
    localparam int TARGET_ID_BITS = 10;

    localparam int IDX_W       = $clog2(TABLE_ENTRIES);
    localparam int CNT_W       = $clog2(TABLE_ENTRIES + 1);
    localparam int REMOVED_W   = 9;
    localparam int REMOVED_MAX = (1 << REMOVED_W) - 1;

    typedef logic [IDX_W-1:0] addr_t;

    typedef enum logic [1:0] {
        OP_LOOKUP        = 2'd0,
        OP_BIND          = 2'd1,
        OP_UNBIND_KEY    = 2'd2,
        OP_UNBIND_TARGET = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_NOT_BOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_READ_LAST,
        ST_MOVE,
        ST_DONE
    } state_t;

    // scan phases: key search, target purge, key search after purge
    typedef enum logic [1:0] {
        PH_FIND,
        PH_PURGE,
        PH_REFIND
    } phase_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]       key;
        logic                      kind;
        logic [TARGET_ID_BITS-1:0] id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic   we;
        addr_t  waddr;
        entry_t wdata;
        addr_t  raddr;
    } mem_req_t;

    typedef struct packed {
        status_t                   status;
        logic                      found;
        logic                      kind;
        logic [TARGET_ID_BITS-1:0] id;
        logic [REMOVED_W-1:0]      removed;
    } result_t;

    // clamp a removal count to the result field
    function automatic logic [REMOVED_W-1:0] sat_removed(input logic [CNT_W-1:0] n);
        if (32'(n) > 32'(REMOVED_MAX))
            return REMOVED_W'(REMOVED_MAX);
        else
            return REMOVED_W'(n);
    endfunction

endpackage

@@ hdl/key_binding_table.sv @@
// key binding table: packed table of key -> target bindings
//
// input channel (in_valid/in_ready) carries one operation per beat: lookup,
// bind, unbind key or unbind every entry of a target. output channel
// (out_valid/out_ready) returns exactly one result beat per operation with
// status, found flag, target of a found lookup and number of entries removed.
//
// the entries live in one single-port-read, single-port-write ram with a
// registered read port; a sequencer walks the packed region, reading each
// entry in a read state and checking it in a check state, and deletes by
// copying the last entry into the hole (read-last and move states; in a
// purge the filled slot is checked again). a lookup over a full table
// visits up to 256 entries, and a bind with unique target scans up to
// three times. one operation is in the sequencer at a time; in_ready is
// high only while it is idle.
//
// results land in an output register, so the sequencer may take the next
// beat while a result waits; a stalled receiver holds that register and
// then the sequencer stops in its done state. reset empties the table
// (entry count to zero) at once; ram contents are not cleared.
module key_binding_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [15:0] key_code,
    input  logic        target_kind,
    input  logic [9:0]  target_id,
    input  logic        unique_target,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        found,
    output logic        out_kind,
    output logic [9:0]  out_id,
    output logic [8:0]  removed_count
);

    import kbt_pkg::*;

    mem_req_t             mem_req;
    logic [ENTRY_W-1:0]   ram_rdata;
    entry_t               rd_entry;
    logic                 res_valid;
    logic                 res_ready;
    result_t              res;

    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;

    assign rd_entry = ram_rdata;

    kbt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (ram_rdata)
    );

    kbt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op_t'(op)),
        .key       (key_code[KEY_BITS-1:0]),
        .kind      (target_kind),
        .id        (target_id[TARGET_ID_BITS-1:0]),
        .uniq      (unique_target),
        .mem_req   (mem_req),
        .mem_rdata (rd_entry),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register takes a result whenever it is empty or being drained
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign found         = out_reg.found;
    assign out_kind      = out_reg.kind;
    assign out_id        = 10'(out_reg.id);
    assign removed_count = out_reg.removed;

endmodule

@@ hdl/kbt_ram.sv @@
module kbt_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/kbt_ctrl.sv @@
module kbt_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  kbt_pkg::op_t                        op,
    input  logic [kbt_pkg::KEY_BITS-1:0]        key,
    input  logic                                kind,
    input  logic [kbt_pkg::TARGET_ID_BITS-1:0]  id,
    input  logic                                uniq,
    output kbt_pkg::mem_req_t                   mem_req,
    input  kbt_pkg::entry_t                     mem_rdata,
    output logic                                res_valid,
    input  logic                                res_ready,
    output kbt_pkg::result_t                    res
);

    import kbt_pkg::*;

    state_t                    state_reg, state_next;
    phase_t                    phase_reg, phase_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          removed_reg, removed_next;
    logic                      found_reg, found_next;
    logic                      okind_reg, okind_next;
    logic [TARGET_ID_BITS-1:0] oid_reg, oid_next;
    status_t                   status_reg, status_next;
    op_t                       op_reg, op_next;
    logic [KEY_BITS-1:0]       key_reg, key_next;
    logic                      kind_reg, kind_next;
    logic [TARGET_ID_BITS-1:0] id_reg, id_next;
    logic                      uniq_reg, uniq_next;

    logic [CNT_W-1:0]          last_idx;
    logic                      hit;
    logic                      append_req;
    logic                      overwrite_req;

    assign last_idx = count_reg - CNT_W'(1);
    assign hit = (phase_reg == PH_PURGE)
               ? (mem_rdata.kind == kind_reg && mem_rdata.id == id_reg)
               : (mem_rdata.key == key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_FIND;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        removed_reg <= removed_next;
        found_reg   <= found_next;
        okind_reg   <= okind_next;
        oid_reg     <= oid_next;
        status_reg  <= status_next;
        op_reg      <= op_next;
        key_reg     <= key_next;
        kind_reg    <= kind_next;
        id_reg      <= id_next;
        uniq_reg    <= uniq_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        removed_next  = removed_reg;
        found_next    = found_reg;
        okind_next    = okind_reg;
        oid_next      = oid_reg;
        status_next   = status_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        kind_next     = kind_reg;
        id_next       = id_reg;
        uniq_next     = uniq_reg;
        append_req    = 1'b0;
        overwrite_req = 1'b0;

        in_ready      = 1'b0;
        res_valid     = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = idx_reg[IDX_W-1:0];
        mem_req.wdata = '{key: key_reg, kind: kind_reg, id: id_reg};
        mem_req.raddr = idx_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next      = op;
                    key_next     = key;
                    kind_next    = kind;
                    id_next      = id;
                    uniq_next    = uniq;
                    idx_next     = '0;
                    removed_next = '0;
                    found_next   = 1'b0;
                    okind_next   = 1'b0;
                    oid_next     = '0;
                    status_next  = STATUS_DONE;
                    phase_next   = (op == OP_UNBIND_TARGET) ? PH_PURGE : PH_FIND;
                    state_next   = ST_READ;
                end
            end

            ST_READ:
            begin
                if (idx_reg < count_reg)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    // scan ran off the end of the packed region
                    case (phase_reg)
                        PH_FIND:
                        begin
                            if (op_reg == OP_BIND)
                            begin
                                if (uniq_reg)
                                begin
                                    phase_next = PH_PURGE;
                                    idx_next   = '0;
                                end
                                else
                                begin
                                    append_req = 1'b1;
                                end
                            end
                            else
                            begin
                                status_next = STATUS_NOT_BOUND;
                                state_next  = ST_DONE;
                            end
                        end
                        PH_PURGE:
                        begin
                            if (op_reg == OP_BIND)
                            begin
                                phase_next = PH_REFIND;
                                idx_next   = '0;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        default:
                        begin
                            append_req = 1'b1;
                        end
                    endcase
                end
            end

            ST_CHECK:
            begin
                if (!hit)
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_READ;
                end
                else
                begin
                    case (phase_reg)
                        PH_FIND:
                        begin
                            found_next = 1'b1;
                            case (op_reg)
                                OP_LOOKUP:
                                begin
                                    okind_next = mem_rdata.kind;
                                    oid_next   = mem_rdata.id;
                                    state_next = ST_DONE;
                                end
                                OP_UNBIND_KEY:
                                begin
                                    removed_next = CNT_W'(1);
                                    state_next   = ST_READ_LAST;
                                end
                                OP_BIND:
                                begin
                                    if (uniq_reg)
                                    begin
                                        phase_next = PH_PURGE;
                                        idx_next   = '0;
                                        state_next = ST_READ;
                                    end
                                    else
                                    begin
                                        overwrite_req = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    state_next = ST_DONE;
                                end
                            endcase
                        end
                        PH_PURGE:
                        begin
                            removed_next = removed_reg + CNT_W'(1);
                            state_next   = ST_READ_LAST;
                        end
                        default:
                        begin
                            overwrite_req = 1'b1;
                        end
                    endcase
                end
            end

            ST_READ_LAST:
            begin
                // fetch the last entry to fill the hole
                mem_req.raddr = last_idx[IDX_W-1:0];
                state_next    = ST_MOVE;
            end

            ST_MOVE:
            begin
                mem_req.we    = 1'b1;
                mem_req.wdata = mem_rdata;
                count_next    = last_idx;
                // purge re-checks the slot that was just filled
                state_next    = (phase_reg == PH_PURGE) ? ST_READ : ST_DONE;
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (overwrite_req)
        begin
            mem_req.we = 1'b1;
            state_next = ST_DONE;
        end

        if (append_req)
        begin
            if (count_reg == CNT_W'(TABLE_ENTRIES))
            begin
                status_next = STATUS_FULL;
            end
            else
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = count_reg[IDX_W-1:0];
                count_next    = count_reg + CNT_W'(1);
            end
            state_next = ST_DONE;
        end
    end

    assign res.status  = status_reg;
    assign res.found   = found_reg;
    assign res.kind    = okind_reg;
    assign res.id      = oid_reg;
    assign res.removed = sat_removed(removed_reg);

    a_move_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MOVE |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("swap delete did not shrink the table");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !mem_req.we)
        else $error("table written while idle");

    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.found |-> res.status == STATUS_DONE)
        else $error("bound key reported with error status");

    a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ && idx_reg >= count_reg
        && count_reg == CNT_W'(TABLE_ENTRIES) |-> !mem_req.we)
        else $error("append into a full table");

endmodule
